// File: rtl/trht_pkg.sv
`default_nettype none

package trht_pkg;

  // Store geometry
  localparam int MAX_RECTS  = 1024;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W      = $clog2(MAX_RECTS + 1);
  localparam int RECT_W     = 4 * COORD_BITS;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int HIT_W    = 11;

  // Opcodes (the high bit alone selects a query)
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ADDED    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_QUERY    = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t ex;
    coord_t ey;
  } rect_t;

endpackage

`default_nettype wire

// File: rtl/trht_ram.sv
`default_nettype none

module trht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/topmost_rectangle_hit_test_core.sv
`default_nettype none

// Topmost rectangle hit test. Keeps a stack of up to MAX_RECTS axis-aligned
// rectangles (corner plus width and height, bounds inclusive, the far edge
// formed one bit wider so it never wraps) in a single-port-read, single-port-
// write RAM. Opcode clear empties the stack, add pushes one rectangle (status
// rejected when full), query returns the 1-based number of the newest
// rectangle covering the point, or not found. One item is processed at a
// time. Clear and add pass from idle through a post state, where their result
// is loaded into the output register once no earlier result is held there by
// out_ready. A query first scans the stack through the RAM read port, one
// entry per cycle, newest first, up to and including a hit or down to the
// bottom of the stack (no entry on an empty stack, at most the stored count,
// up to 1024), then passes through the same post state. The result sits in an
// output register, so the next input transfer is taken while an earlier
// result still waits for out_ready.
module topmost_rectangle_hit_test_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [trht_pkg::OP_W-1:0]        in_opcode,
  input  wire logic [15:0]                      in_coord_x,
  input  wire logic [15:0]                      in_coord_y,
  input  wire logic [15:0]                      in_extent_x,
  input  wire logic [15:0]                      in_extent_y,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [trht_pkg::STATUS_W-1:0]    out_status,
  output logic                                  out_hit_found,
  output logic      [trht_pkg::HIT_W-1:0]       out_hit_number
);

  import trht_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0]          st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  coord_t              px_r, py_r;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;
  logic [HIT_W-1:0]    res_number_r, res_number_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_hit_found_r;
  logic [HIT_W-1:0]    out_hit_number_r;

  logic                in_xfer;
  logic                full;
  logic                post_go;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  rect_t               ram_wdata;
  rect_t               ram_rdata;

  logic [COORD_BITS:0] far_x, far_y;
  logic                covers;
  logic [CNT_W-1:0]    hit_num;

  assign in_ready = (st_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (cnt_r == CNT_W'(MAX_RECTS));
  assign post_go  = (st_r == S_POST) && (!out_valid_r || out_ready);

  // Push a rectangle at the top of the stack; the scan never overlaps a
  // write because only one item is in flight.
  assign ram_we    = in_xfer && (in_opcode == OP_ADD) && !full;
  assign ram_wdata = '{cx: coord_t'(in_coord_x), cy: coord_t'(in_coord_y),
                       ex: coord_t'(in_extent_x), ey: coord_t'(in_extent_y)};

  // Start at the newest entry on a query, then step down one entry a cycle.
  always_comb begin
    if (st_r == S_IDLE) begin
      ram_raddr = ADDR_W'(cnt_r - CNT_W'(1));
    end else begin
      ram_raddr = idx_r - ADDR_W'(1);
    end
  end

  trht_ram #(
    .WIDTH (RECT_W),
    .DEPTH (MAX_RECTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Inclusive bounds, far edge one bit wider.
  assign far_x  = {1'b0, ram_rdata.cx} + {1'b0, ram_rdata.ex};
  assign far_y  = {1'b0, ram_rdata.cy} + {1'b0, ram_rdata.ey};
  assign covers = (px_r >= ram_rdata.cx) && ({1'b0, px_r} <= far_x) &&
                  (py_r >= ram_rdata.cy) && ({1'b0, py_r} <= far_y);
  assign hit_num = CNT_W'(idx_r) + CNT_W'(1);

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_number_nxt = res_number_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_found_nxt  = 1'b0;
          res_number_nxt = '0;
          st_nxt         = S_POST;
          unique case (in_opcode)
            OP_CLEAR: begin
              cnt_nxt        = '0;
              res_status_nxt = STAT_CLEARED;
            end
            OP_ADD: begin
              if (full) begin
                res_status_nxt = STAT_REJECTED;
              end else begin
                cnt_nxt        = cnt_r + CNT_W'(1);
                res_status_nxt = STAT_ADDED;
              end
            end
            default: begin
              // Both codes with the high bit set query.
              res_status_nxt = STAT_QUERY;
              if (cnt_r != '0) begin
                idx_nxt = ADDR_W'(cnt_r - CNT_W'(1));
                st_nxt  = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (covers) begin
          res_found_nxt  = 1'b1;
          res_number_nxt = HIT_W'(hit_num);
          st_nxt         = S_POST;
        end else if (idx_r == '0) begin
          st_nxt = S_POST;
        end else begin
          idx_nxt = idx_r - ADDR_W'(1);
        end
      end
      S_POST: begin
        if (post_go) begin
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_number_r <= res_number_nxt;
    if (in_xfer) begin
      px_r <= coord_t'(in_coord_x);
      py_r <= coord_t'(in_coord_y);
    end
    if (post_go) begin
      out_status_r     <= res_status_r;
      out_hit_found_r  <= res_found_r;
      out_hit_number_r <= res_number_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hit_found  = out_hit_found_r;
  assign out_hit_number = out_hit_number_r;

  // Count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RECTS))
    else $error("rectangle count above store depth");

  // The scan only touches written entries.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN) |-> (CNT_W'(idx_r) < cnt_r))
    else $error("scan index beyond stored rectangles");

  // A hit is reported only for a query, with a nonzero number.
  a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_found_r) |->
      (out_status_r == STAT_QUERY) && (out_hit_number_r != '0))
    else $error("hit reported without query status or number");

  // A clear transfer empties the stack.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_opcode == OP_CLEAR)) |=> (cnt_r == '0))
    else $error("clear did not empty the stack");

endmodule

`default_nettype wire

// File: dv/topmost_hit_checker.sv
module topmost_hit_checker
  import trht_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [OP_W-1:0]     in_opcode,
  input  wire logic [15:0]         in_coord_x,
  input  wire logic [15:0]         in_coord_y,
  input  wire logic [15:0]         in_extent_x,
  input  wire logic [15:0]         in_extent_y,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [STATUS_W-1:0] out_status,
  input  wire logic                out_hit_found,
  input  wire logic [HIT_W-1:0]    out_hit_number,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [HIT_W-1:0]    number;
  } hit_result_t;

  rect_t       rect_stack [MAX_RECTS];
  int unsigned stack_depth;
  hit_result_t expected_hits [$];

  // Inclusive span test; the far edge is one bit wider so it never wraps.
  function automatic bit spans(coord_t lo, coord_t len, coord_t p);
    logic [COORD_BITS:0] far_edge;
    far_edge = {1'b0, lo} + {1'b0, len};
    return (p >= lo) && ({1'b0, p} <= far_edge);
  endfunction

  // Apply one item to the shadow stack and return the result it should give.
  function automatic hit_result_t predict_hit(logic [OP_W-1:0] op, coord_t x, coord_t y,
                                              coord_t ex, coord_t ey);
    hit_result_t r;
    r = '0;
    if (op == OP_CLEAR) begin
      stack_depth = 0;
      r.status = STAT_CLEARED;
    end else if (op == OP_ADD) begin
      if (stack_depth >= MAX_RECTS) begin
        r.status = STAT_REJECTED;
      end else begin
        rect_stack[stack_depth] = '{cx: x, cy: y, ex: ex, ey: ey};
        stack_depth++;
        r.status = STAT_ADDED;
      end
    end else begin
      // high opcode bit alone selects a query; scan newest first
      r.status = STAT_QUERY;
      for (int i = stack_depth; i > 0; i--) begin
        if (spans(rect_stack[i-1].cx, rect_stack[i-1].ex, x) &&
            spans(rect_stack[i-1].cy, rect_stack[i-1].ey, y)) begin
          r.found  = 1'b1;
          r.number = HIT_W'(i);
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hit_result_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      stack_depth = 0;
      expected_hits.delete();
    end else begin
      // a result never leaves on the edge its own item arrives, so pop first
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result, status %0d found %0d number %0d",
                   $time, out_status, out_hit_found, out_hit_number);
          errs++;
        end else begin
          want = expected_hits.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_status);
            errs++;
          end
          if (out_hit_found !== want.found) begin
            $display("%0t: hit_found mismatch, expected %0d actual %0d",
                     $time, want.found, out_hit_found);
            errs++;
          end
          if (out_hit_number !== want.number) begin
            $display("%0t: hit_number mismatch, expected %0d actual %0d",
                     $time, want.number, out_hit_number);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_hits.push_back(predict_hit(in_opcode, in_coord_x, in_coord_y,
                                            in_extent_x, in_extent_y));
    end
    fail_count    <= fail_count + errs;
    pending_count <= expected_hits.size();
  end

endmodule

// File: dv/testbench.sv
module testbench;
  import trht_pkg::*;

  // Opcode three has the high bit set, so the block decodes it as a query.
  localparam logic [OP_W-1:0] OP_QUERY_ALT = 2'd3;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic [OP_W-1:0]     in_opcode   = OP_CLEAR;
  logic [15:0]         in_coord_x  = '0;
  logic [15:0]         in_coord_y  = '0;
  logic [15:0]         in_extent_x = '0;
  logic [15:0]         in_extent_y = '0;
  logic                out_ready   = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_hit_found;
  logic [HIT_W-1:0]    out_hit_number;

  int fail_count;
  int pending_count;

  // Idle percentages: the sender's is only read by the stimulus process, the
  // receiver's is updated with nonblocking writes since another block reads it.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Stimulus-side view of the stack: fill level (to keep query scans short)
  // and the last few rectangles (to aim points at their edges).
  int          stack_fill = 0;
  logic [63:0] recent_rects [$];

  topmost_rectangle_hit_test_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_extent_x    (in_extent_x),
    .in_extent_y    (in_extent_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_hit_found  (out_hit_found),
    .out_hit_number (out_hit_number)
  );

  topmost_hit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_extent_x    (in_extent_x),
    .in_extent_y    (in_extent_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_hit_found  (out_hit_found),
    .out_hit_number (out_hit_number),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: stall at random while the current phase asks for it.
  always @(posedge clk)
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  // Idling phases: none, sender only, receiver only, both lightly.
  task automatic set_phase(input int p);
    case (p % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_idle_pct  = 62;
        recv_stall_pct <= 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct <= 62;
      end
      default: begin
        send_idle_pct  = 10;
        recv_stall_pct <= 10;
      end
    endcase
  endtask

  // Present one item and hold it until the transfer. Valid is only dropped
  // when an idle gap is taken, so it sees one write per clock step.
  task automatic push_item(input logic [OP_W-1:0] op, input logic [15:0] x, y, ex, ey);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_coord_x  <= x;
    in_coord_y  <= y;
    in_extent_x <= ex;
    in_extent_y <= ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Clear with junk in the unused fields.
  task automatic clear_stack();
    push_item(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    stack_fill = 0;
    recent_rects.delete();
  endtask

  task automatic add_rect(input logic [15:0] x, y, ex, ey);
    push_item(OP_ADD, x, y, ex, ey);
    if (stack_fill < MAX_RECTS) begin
      stack_fill++;
      recent_rects.push_back({x, y, ex, ey});
      if (recent_rects.size() > 16) void'(recent_rects.pop_front());
    end
  endtask

  // Queries carry random extents; the block must ignore them.
  task automatic query_at(input logic [OP_W-1:0] op, input logic [15:0] x, y);
    push_item(op, x, y, 16'($urandom), 16'($urandom));
  endtask

  // Random rectangle: small and overlapping, full range, hugging the top of
  // the coordinate range (far edge past 16 bits), or a degenerate line.
  task automatic add_random_rect();
    logic [15:0] x, y, ex, ey;
    case ($urandom_range(3))
      0: begin
        x  = 16'($urandom_range(0, 255));
        y  = 16'($urandom_range(0, 255));
        ex = 16'($urandom_range(0, 63));
        ey = 16'($urandom_range(0, 63));
      end
      1: begin
        x  = 16'($urandom);
        y  = 16'($urandom);
        ex = 16'($urandom);
        ey = 16'($urandom);
      end
      2: begin
        x  = 16'hFFFF - 16'($urandom_range(0, 63));
        y  = 16'hFFFF - 16'($urandom_range(0, 63));
        ex = 16'($urandom);
        ey = 16'($urandom_range(0, 127));
      end
      default: begin
        x  = 16'($urandom_range(0, 255));
        y  = 16'($urandom_range(0, 255));
        ex = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 63));
        ey = (ex != 16'd0) ? 16'd0 : 16'($urandom_range(0, 63));
      end
    endcase
    add_rect(x, y, ex, ey);
  endtask

  // Random point: in the crowded corner, anywhere, near the top of the range,
  // or on and just past the edges of a recently added rectangle.
  task automatic query_random();
    logic [15:0]     x, y, cx, cy, ex, ey;
    logic [OP_W-1:0] op;
    op = ($urandom_range(3) == 0) ? OP_QUERY_ALT : OP_QUERY;
    case ($urandom_range(3))
      0: begin
        x = 16'($urandom_range(0, 320));
        y = 16'($urandom_range(0, 320));
      end
      1: begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      2: begin
        x = 16'hFFFF - 16'($urandom_range(0, 80));
        y = 16'hFFFF - 16'($urandom_range(0, 80));
      end
      default: begin
        if (recent_rects.size() == 0) begin
          x = 16'($urandom_range(0, 320));
          y = 16'($urandom_range(0, 320));
        end else begin
          {cx, cy, ex, ey} = recent_rects[$urandom_range(recent_rects.size() - 1)];
          case ($urandom_range(3))
            0: x = cx;
            1: x = cx + ex;
            2: x = cx - 16'd1;
            default: x = cx + ex + 16'd1;
          endcase
          case ($urandom_range(3))
            0: y = cy;
            1: y = cy + ey;
            2: y = cy - 16'd1;
            default: y = cy + ey + 16'd1;
          endcase
        end
      end
    endcase
    query_at(op, x, y);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, extremes, inclusive edges, newest-first order,
    // opcode three, and clear.
    set_phase(0);
    query_at(OP_QUERY, 16'd0, 16'd0);
    query_at(OP_QUERY_ALT, 16'hFFFF, 16'hFFFF);
    add_rect(16'd0, 16'd0, 16'd0, 16'd0);
    query_at(OP_QUERY, 16'd0, 16'd0);
    query_at(OP_QUERY, 16'd1, 16'd0);
    add_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    query_at(OP_QUERY, 16'hFFFF, 16'hFFFF);
    query_at(OP_QUERY, 16'hFFFE, 16'hFFFF);
    add_rect(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    query_at(OP_QUERY, 16'd1234, 16'd5678);
    query_at(OP_QUERY, 16'hFFFF, 16'hFFFF);
    add_rect(16'd100, 16'd200, 16'd0, 16'd50);
    query_at(OP_QUERY, 16'd100, 16'd250);
    query_at(OP_QUERY, 16'd100, 16'd251);
    query_at(OP_QUERY_ALT, 16'd100, 16'd200);
    add_rect(16'd10, 16'd10, 16'd5, 16'd5);
    query_at(OP_QUERY, 16'd15, 16'd15);
    query_at(OP_QUERY, 16'd9, 16'd10);
    clear_stack();
    query_at(OP_QUERY, 16'd0, 16'd0);
    add_rect(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00);
    query_at(OP_QUERY, 16'h5600, 16'hAAAA);

    // Random traffic: keep the stack shallow so scans stay short, with
    // frequent clears once it grows.
    for (int i = 0; i < 558; i++) begin
      if (i % 40 == 0) set_phase(i / 40);
      if ((stack_fill > 48 && $urandom_range(99) < 30) || $urandom_range(99) < 4)
        clear_stack();
      else if ($urandom_range(99) < 45)
        add_random_rect();
      else
        query_random();
    end

    // Drain: drop valid, let the outstanding count catch up, then allow one
    // full scan's worth of cycles for any stray result.
    in_valid <= 1'b0;
    set_phase(0);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
